// File: hw/rtl/adc_level_change_reporter_assert.svh
// assertion macros for the rtl
`ifndef ADC_LEVEL_CHANGE_REPORTER_ASSERT_SVH
`define ADC_LEVEL_CHANGE_REPORTER_ASSERT_SVH

// same-cycle implication, held off during reset
`define ALCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ALCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/alcr_pkg.sv
`timescale 1ns / 1ps

package alcr_pkg;

    localparam int SAMPLE_W = 10;
    localparam int LEVEL_W  = 8;
    localparam int DIGIT_W  = 4;
    localparam int BEAT_W   = 2;

    localparam logic [LEVEL_W-1:0] DEADBAND_RESET = 8'd1;
    localparam logic [7:0]         CH_ZERO        = 8'h30;
    localparam logic [7:0]         CH_NEWLINE     = 8'h0A;

    // position of a character within a report
    localparam logic [BEAT_W-1:0] BEAT_HUNDREDS = 2'd0;
    localparam logic [BEAT_W-1:0] BEAT_TENS     = 2'd1;
    localparam logic [BEAT_W-1:0] BEAT_ONES     = 2'd2;
    localparam logic [BEAT_W-1:0] BEAT_NEWLINE  = 2'd3;

    typedef struct packed {
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } digits_t;

    // decimal split of an 8-bit level: compare-subtract for hundreds,
    // reciprocal multiply for tens (exact for every 7-bit remainder)
    function automatic digits_t to_digits(input logic [LEVEL_W-1:0] level);
        digits_t     d;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [7:0]  tens_x10;
        begin
            if (level >= 8'd200)
            begin
                d.hundreds = 4'd2;
                rem        = 7'(level - 8'd200);
            end
            else if (level >= 8'd100)
            begin
                d.hundreds = 4'd1;
                rem        = 7'(level - 8'd100);
            end
            else
            begin
                d.hundreds = 4'd0;
                rem        = level[6:0];
            end
            prod     = 15'(rem) * 15'd205;
            d.tens   = prod[14:11];
            tens_x10 = {d.tens, 3'b000} + {3'b000, d.tens, 1'b0};
            d.ones   = 4'({1'b0, rem} - tens_x10);
            return d;
        end
    endfunction

endpackage

// File: hw/rtl/alcr_if.sv
`timescale 1ns / 1ps

// sample channel
interface alcr_sample_if;
    logic                              valid;
    logic                              ready;
    logic [alcr_pkg::SAMPLE_W-1:0]     adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

// result channel
interface alcr_result_if;
    logic                              valid;
    logic                              ready;
    logic [alcr_pkg::LEVEL_W-1:0]      duty;
    logic                              has_char;
    logic [7:0]                        char_byte;
    logic                              last;

    modport source (output valid, output duty, output has_char, output char_byte,
                    output last, input ready);
    modport sink   (input valid, input duty, input has_char, input char_byte,
                    input last, output ready);
endinterface

// File: hw/rtl/adc_level_change_reporter.sv
// channel      | dir | payload                              | handshake
// sample_in    | in  | adc_sample[9:0]                      | valid / ready
// result_out   | out | duty[7:0] has_char char_byte[7:0] last| valid / ready
// cfg          | in  | cfg_wdata[7:0] (deadband)            | cfg_we, no wait
//
// a sample is compared against the reported level and split into decimal
// digits in the cycle it is accepted, then held in one item register
// a reporting sample gives four results (one per cycle while result_out is
// ready), any other sample one, stepped by the output beat counter; the next
// sample is taken in the same cycle as the final result
// reset: deadband 1, reported level 0, no item held; stalls on result_out
// hold the item register and back-pressure sample_in
`timescale 1ns / 1ps

module adc_level_change_reporter
(
    input  logic                  clk,
    input  logic                  rst_n,
    alcr_sample_if.sink           sample_in,
    alcr_result_if.source         result_out,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata
);

    `include "adc_level_change_reporter_assert.svh"

    // configuration and persistent state
    logic [alcr_pkg::LEVEL_W-1:0] deadband_reg;
    logic [alcr_pkg::LEVEL_W-1:0] reported_level_reg;

    // item register
    logic                         busy_reg;
    logic [alcr_pkg::BEAT_W-1:0]  beat_reg;
    logic [alcr_pkg::LEVEL_W-1:0] level_reg;
    logic                         report_reg;
    alcr_pkg::digits_t            digits_reg;

    // front-end decode of the incoming sample
    logic [alcr_pkg::LEVEL_W-1:0] level_in;
    logic [alcr_pkg::LEVEL_W-1:0] diff;
    logic                         report_next;
    alcr_pkg::digits_t            digits_next;

    logic in_acc;
    logic out_acc;
    logic final_beat;

    assign level_in    = sample_in.adc_sample[alcr_pkg::SAMPLE_W-1:2];
    assign diff        = (level_in > reported_level_reg) ? level_in - reported_level_reg
                                                         : reported_level_reg - level_in;
    assign report_next = diff > deadband_reg;
    assign digits_next = alcr_pkg::to_digits(level_in);

    // last result of the held item: the newline of a report, or the lone result
    assign final_beat = !report_reg || (beat_reg == alcr_pkg::BEAT_NEWLINE);

    assign out_acc = result_out.valid && result_out.ready;
    assign in_acc  = sample_in.valid && sample_in.ready;

    // free slot, or the slot empties this cycle
    assign sample_in.ready = !busy_reg || (result_out.ready && final_beat);

    // result payload straight from the item register
    assign result_out.valid    = busy_reg;
    assign result_out.duty     = level_reg;
    assign result_out.has_char = report_reg;
    assign result_out.last     = final_beat;

    always_comb
    begin
        if (!report_reg)
        begin
            result_out.char_byte = 8'h00;
        end
        else
        begin
            case (beat_reg)
                alcr_pkg::BEAT_HUNDREDS:
                    result_out.char_byte = alcr_pkg::CH_ZERO | {4'h0, digits_reg.hundreds};
                alcr_pkg::BEAT_TENS:
                    result_out.char_byte = alcr_pkg::CH_ZERO | {4'h0, digits_reg.tens};
                alcr_pkg::BEAT_ONES:
                    result_out.char_byte = alcr_pkg::CH_ZERO | {4'h0, digits_reg.ones};
                default:
                    result_out.char_byte = alcr_pkg::CH_NEWLINE;
            endcase
        end
    end

    // deadband register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg <= alcr_pkg::DEADBAND_RESET;
        end
        else if (cfg_we)
        begin
            deadband_reg <= cfg_wdata;
        end
    end

    // reported level moves when a report is taken in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_level_reg <= '0;
        end
        else if (in_acc && report_next)
        begin
            reported_level_reg <= level_in;
        end
    end

    // item control: occupancy and beat counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            beat_reg <= alcr_pkg::BEAT_HUNDREDS;
        end
        else if (in_acc)
        begin
            busy_reg <= 1'b1;
            beat_reg <= alcr_pkg::BEAT_HUNDREDS;
        end
        else if (out_acc)
        begin
            if (final_beat)
            begin
                busy_reg <= 1'b0;
                beat_reg <= alcr_pkg::BEAT_HUNDREDS;
            end
            else
            begin
                beat_reg <= beat_reg + 2'd1;
            end
        end
    end

    // item payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            level_reg  <= level_in;
            report_reg <= report_next;
            digits_reg <= digits_next;
        end
    end

    // a report moves the reported level to the new sample's level
    `ALCR_ASSERT_NEXT(a_level_update, clk, rst_n, in_acc && report_next,
                      reported_level_reg == $past(level_in))
    // a non-reporting item never advances past its first beat
    `ALCR_ASSERT_SAME(a_beat_only_report, clk, rst_n, beat_reg != alcr_pkg::BEAT_HUNDREDS,
                      busy_reg && report_reg)
    // a newly taken item starts at its first beat
    `ALCR_ASSERT_NEXT(a_new_item_start, clk, rst_n, in_acc,
                      busy_reg && beat_reg == alcr_pkg::BEAT_HUNDREDS)
    // a taken result that is not final steps to the next character
    `ALCR_ASSERT_NEXT(a_beat_step, clk, rst_n, out_acc && !final_beat,
                      busy_reg && beat_reg == $past(beat_reg) + 2'd1)

endmodule

// File: dv/adc_level_change_reporter_checker.sv
`timescale 1ns / 1ps

module adc_level_change_reporter_checker
(
    input  logic       clk,
    input  logic       rst_n,
    alcr_sample_if     smp,
    alcr_result_if     res,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    output int         mismatch_count,
    output int         expected_left
);

    typedef struct packed {
        logic [alcr_pkg::LEVEL_W-1:0] duty;
        logic                         has_char;
        logic [7:0]                   char_byte;
        logic                         last;
    } beat_t;

    beat_t                        expected_beats[$];
    logic [alcr_pkg::LEVEL_W-1:0] deadband_q;
    logic [alcr_pkg::LEVEL_W-1:0] reported_q;

    // queue the beats that one sample gives, moving the reported level on a report
    task automatic predict_level_report(input logic [alcr_pkg::SAMPLE_W-1:0] sample);
        logic [alcr_pkg::LEVEL_W-1:0] level;
        logic [alcr_pkg::LEVEL_W-1:0] diff;
        beat_t                        b;
        level = sample[alcr_pkg::SAMPLE_W-1:2];
        diff  = (level > reported_q) ? level - reported_q : reported_q - level;
        b.duty = level;
        if (diff > deadband_q)
        begin
            reported_q  = level;
            b.has_char  = 1'b1;
            b.last      = 1'b0;
            b.char_byte = alcr_pkg::CH_ZERO + 8'(level / 100);
            expected_beats.push_back(b);
            b.char_byte = alcr_pkg::CH_ZERO + 8'((level / 10) % 10);
            expected_beats.push_back(b);
            b.char_byte = alcr_pkg::CH_ZERO + 8'(level % 10);
            expected_beats.push_back(b);
            b.char_byte = alcr_pkg::CH_NEWLINE;
            b.last      = 1'b1;
            expected_beats.push_back(b);
        end
        else
        begin
            b.has_char  = 1'b0;
            b.char_byte = 8'h00;
            b.last      = 1'b1;
            expected_beats.push_back(b);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beat_t want;
        if (!rst_n)
        begin
            deadband_q     = alcr_pkg::DEADBAND_RESET;
            reported_q     = '0;
            mismatch_count = 0;
            expected_beats.delete();
        end
        else
        begin
            if (cfg_we)
                deadband_q = cfg_wdata;
            if (smp.valid && smp.ready)
                predict_level_report(smp.adc_sample);
            if (res.valid && res.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    mismatch_count++;
                    $error("unexpected result: duty %0d char_byte %0h", res.duty, res.char_byte);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (res.duty !== want.duty)
                    begin
                        mismatch_count++;
                        $error("duty: expected %0d, actual %0d", want.duty, res.duty);
                    end
                    if (res.has_char !== want.has_char)
                    begin
                        mismatch_count++;
                        $error("has_char: expected %0d, actual %0d", want.has_char,
                               res.has_char);
                    end
                    if (res.char_byte !== want.char_byte)
                    begin
                        mismatch_count++;
                        $error("char_byte: expected %0h, actual %0h", want.char_byte,
                               res.char_byte);
                    end
                    if (res.last !== want.last)
                    begin
                        mismatch_count++;
                        $error("last: expected %0d, actual %0d", want.last, res.last);
                    end
                end
            end
        end
        expected_left = expected_beats.size();
    end

endmodule

// File: dv/adc_level_change_reporter_test.sv
`timescale 1ns / 1ps

module adc_level_change_reporter_test;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [7:0] cfg_wdata;

    int mismatch_count;
    int expected_left;

    // idle chances in percent for the two sides, changed per phase
    int src_idle_pct;
    int sink_idle_pct;

    // last level sent, used to aim samples near the deadband edge
    int last_level;
    int cur_deadband;

    alcr_sample_if smp ();
    alcr_result_if res ();

    adc_level_change_reporter dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (smp),
        .result_out (res),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    adc_level_change_reporter_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .smp            (smp),
        .res            (res),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #5ms;
        $display("[adc_level_change_reporter] ERROR");
        $finish;
    end

    // receiver back-pressure, redrawn on every falling edge
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n)
                res.ready = ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // offer one item, with random idle cycles in front; returns on the falling
    // edge after acceptance with valid lowered (a following call with no idle
    // draw raises it again in the same step, so no gap shows at the clock edge)
    task automatic send_sample(input logic [alcr_pkg::SAMPLE_W-1:0] s);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            smp.valid = 1'b0;
            @(negedge clk);
        end
        smp.valid      = 1'b1;
        smp.adc_sample = s;
        last_level     = int'(s[alcr_pkg::SAMPLE_W-1:2]);
        do
            @(posedge clk);
        while (!smp.ready);
        @(negedge clk);
        smp.valid = 1'b0;
    endtask

    // hold the sender until every outstanding result has come out, plus a margin
    task automatic wait_drained();
        while (expected_left != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // deadband writes only while the block is idle
    task automatic set_deadband(input logic [7:0] v);
        wait_drained();
        cfg_we       = 1'b1;
        cfg_wdata    = v;
        cur_deadband = int'(v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // random sample: most often around the last level at about deadband distance,
    // otherwise anywhere, or on the full-scale and digit-rollover boundaries
    function automatic logic [alcr_pkg::SAMPLE_W-1:0] pick_sample();
        int sel;
        int span;
        int lvl;
        int edges[6];
        edges = '{0, 99, 100, 199, 200, 255};
        sel   = $urandom_range(0, 99);
        if (sel < 45)
        begin
            span = (cur_deadband > 40) ? 40 : cur_deadband;
            lvl  = last_level + $urandom_range(0, 2 * span + 6) - (span + 3);
            if (lvl < 0)
                lvl = 0;
            if (lvl > 255)
                lvl = 255;
            return {8'(lvl), 2'($urandom_range(0, 3))};
        end
        else if (sel < 85)
            return alcr_pkg::SAMPLE_W'($urandom_range(0, 1023));
        else
            return {8'(edges[$urandom_range(0, 5)]), 2'($urandom_range(0, 3))};
    endfunction

    initial
    begin
        logic [alcr_pkg::SAMPLE_W-1:0] directed_db1[14];
        logic [7:0] chunk_db[12];
        int ph;
        int ch;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        smp.valid      = 1'b0;
        smp.adc_sample = '0;
        src_idle_pct   = 29;
        sink_idle_pct  = 87;
        last_level     = 0;
        cur_deadband   = 1;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset deadband of 1: no change, change of exactly one (held back),
        // change of two, full scale both ways, and the 99/100 and 199/200 rollovers
        directed_db1 = '{10'd0, 10'd7, 10'd8, 10'd11, 10'd1023, 10'd1020, 10'd0,
                         10'd399, 10'd403, 10'd412, 10'd800, 10'd799, 10'd780,
                         10'd1023};
        foreach (directed_db1[i])
            send_sample(directed_db1[i]);

        // deadband 0: any change at all reports, no change does not
        set_deadband(8'd0);
        send_sample(10'd1019);
        send_sample(10'd1019);
        send_sample(10'd1);
        send_sample(10'd4);

        // deadband 255: nothing can report
        set_deadband(8'd255);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd1023);

        // deadband 254: a full swing from level one falls short
        set_deadband(8'd254);
        send_sample(10'd1023);
        send_sample(10'd0);

        // random part: three idling phases, four deadband settings each
        chunk_db = '{8'd0, 8'd1, 8'd3, 8'd255,
                     8'd2, 8'd7, 8'd0, 8'd128,
                     8'd1, 8'd12, 8'd254, 8'd5};
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct  = 29;
                    sink_idle_pct = 87;
                end
                1:
                begin
                    src_idle_pct  = 87;
                    sink_idle_pct = 29;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (ch = 0; ch < 4; ch++)
            begin
                // one slot per phase takes a fresh small deadband
                if (ch == 1)
                    set_deadband(8'($urandom_range(0, 20)));
                else
                    set_deadband(chunk_db[ph * 4 + ch]);
                for (int n = 0; n < 34; n++)
                begin
                    // sender holds off mid-chunk until the block has drained
                    if (n == 18 && ch == 2)
                        wait_drained();
                    send_sample(pick_sample());
                end
            end
        end

        // let the last results out, then a margin for the pipeline
        wait_drained();
        repeat (20) @(negedge clk);

        if (mismatch_count == 0)
            $display("[adc_level_change_reporter] OK");
        else
            $display("[adc_level_change_reporter] ERROR");
        $finish;
    end

endmodule
